// ===== rtl/core/bsm_pkg.sv =====
package bsm_pkg;

  // Capacity of the sorted store, in samples.
  localparam int MAX_SAMPLES = 64;

  // Field widths of the transfers.
  localparam int SAMPLE_W = 16;
  localparam int MED_W    = 17;
  localparam int USED_W   = 7;

  // Store index width and the width of a count that can hold MAX_SAMPLES itself.
  localparam int IDX_W = $clog2(MAX_SAMPLES);
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

endpackage

// ===== rtl/core/bsm_ram.sv =====
module bsm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one read port with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/bounded_sample_median_core.sv =====
// Median of a bounded sample sequence. Each transfer on the sample channel carries one
// 16-bit unsigned sample; the first MAX_SAMPLES samples of a sequence are inserted into an
// ascending sorted store, later ones are dropped and the sequence is marked truncated. On
// the sample flagged last the block emits one result: twice the median (the sum of the two
// middle values for an even count), the number of samples kept, and the truncated flag.
// The count then returns to zero for the next sequence. A kept sample moves each stored
// entry larger than it up by one place and is then written into the gap; a dropped sample
// is not stored. After a last sample the two middle entries are read, and the result
// waits while the previous result still waits to be taken. The insertion loop moves one
// entry per cycle through the one write port and one read port of the sample store; no
// new sample is taken until the insertion and any median reads are done.
// A finished result sits in an output register, so the next sequence may start while it
// waits to be taken.
module bounded_sample_median_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_ready,
  input  logic [bsm_pkg::SAMPLE_W-1:0]  sample,
  input  logic                          last,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [bsm_pkg::MED_W-1:0]     median_doubled,
  output logic [bsm_pkg::USED_W-1:0]    samples_used,
  output logic                          truncated
);

  import bsm_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    SHIFT,
    MED_A,
    MED_B,
    MED_C
  } state_t;

  state_t              state;
  logic [CNT_W-1:0]    count;
  logic                overflow_seen;
  logic [IDX_W-1:0]    pos;
  logic [SAMPLE_W-1:0] value;
  logic                is_last;
  logic [SAMPLE_W-1:0] lo_value;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [SAMPLE_W-1:0] ram_wdata;
  logic [IDX_W-1:0]    ram_raddr;
  logic [SAMPLE_W-1:0] ram_rdata;

  logic                sample_xfer;
  logic                store_full;
  logic                move_up;
  logic                result_load;
  logic [IDX_W-1:0]    hi_idx;
  logic [IDX_W-1:0]    lo_idx;

  assign sample_ready = (state == IDLE);
  assign sample_xfer  = sample_valid && sample_ready;
  assign store_full   = (count == CNT_W'(MAX_SAMPLES));

  // The entry below the insertion point moves up while it is larger than the new sample.
  assign move_up = (pos != '0) && (ram_rdata > value);

  // Middle indexes: equal for an odd count, adjacent for an even count.
  assign hi_idx = IDX_W'(count >> 1);
  assign lo_idx = hi_idx - IDX_W'(!count[0]);

  assign result_load = (state == MED_C) && (!result_valid || result_ready);

  // Store port control: each shift cycle writes one entry and reads the next one down.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos;
    ram_wdata = value;
    ram_raddr = IDX_W'(count - CNT_W'(1));
    case (state)
      IDLE: begin
        ram_raddr = IDX_W'(count - CNT_W'(1));
      end
      SHIFT: begin
        ram_we    = 1'b1;
        ram_wdata = move_up ? ram_rdata : value;
        ram_raddr = pos - IDX_W'(2);
      end
      MED_A: begin
        ram_raddr = lo_idx;
      end
      MED_B, MED_C: begin
        ram_raddr = hi_idx;
      end
      default: begin
        ram_raddr = hi_idx;
      end
    endcase
  end

  bsm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_SAMPLES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer, counters and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      count         <= '0;
      overflow_seen <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      if (result_valid && result_ready && !result_load) begin
        result_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (sample_xfer) begin
            value   <= sample;
            is_last <= last;
            pos     <= IDX_W'(count);
            if (!store_full) begin
              state <= SHIFT;
            end else begin
              overflow_seen <= 1'b1;
              state         <= last ? MED_A : IDLE;
            end
          end
        end
        SHIFT: begin
          if (move_up) begin
            pos <= pos - IDX_W'(1);
          end else begin
            count <= count + CNT_W'(1);
            state <= is_last ? MED_A : IDLE;
          end
        end
        MED_A: begin
          state <= MED_B;
        end
        MED_B: begin
          lo_value <= ram_rdata;
          state    <= MED_C;
        end
        MED_C: begin
          if (result_load) begin
            median_doubled <= {1'b0, lo_value} + {1'b0, ram_rdata};
            samples_used   <= USED_W'(count);
            truncated      <= overflow_seen;
            result_valid   <= 1'b1;
            count          <= '0;
            overflow_seen  <= 1'b0;
            state          <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // The kept count never passes the store capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_SAMPLES))
    else $error("kept count exceeds store capacity");

  // Issuing a result starts a fresh sequence.
  a_clear_after_result: assert property (@(posedge clk) disable iff (rst)
    result_load |=> (count == '0) && !overflow_seen)
    else $error("sequence state not cleared after result");

  // An odd count takes twice one stored value, so the half bit is clear.
  a_odd_even_median: assert property (@(posedge clk) disable iff (rst)
    result_load && count[0] |=> !median_doubled[0])
    else $error("odd count gave a half-valued median");
`endif

endmodule

// ===== verif/tb_bounded_sample_median_core.sv =====
`timescale 1ns / 100ps

module tb_bounded_sample_median_core;
  import bsm_pkg::*;

  // One expected result of a finished sequence.
  typedef struct {
    bit [MED_W-1:0]  median_doubled;
    bit [USED_W-1:0] samples_used;
    bit              truncated;
  } median_result_t;

  // Value shapes for a generated sequence.
  typedef enum int {
    PAT_RANDOM,
    PAT_CLUSTER,
    PAT_EXTREME,
    PAT_DESCENDING,
    PAT_ASCENDING
  } sample_pattern_t;

  // Keeps its own sorted copy of each sequence and the medians it should produce.
  class median_scoreboard;
    bit [SAMPLE_W-1:0] sorted_vals [MAX_SAMPLES];
    int unsigned       held;
    bit                overflowed;
    median_result_t    expected_medians [$];
    int                errors;

    function new();
      held = 0;
      overflowed = 1'b0;
      errors = 0;
    endfunction

    // Insert an accepted sample; on the last one, queue the expected median.
    function void note_sample(bit [SAMPLE_W-1:0] value, bit is_last);
      int unsigned    pos;
      median_result_t res;
      if (held < MAX_SAMPLES) begin
        pos = held;
        // Equal values stay in arrival order, so only strictly larger entries move up.
        while (pos > 0 && sorted_vals[pos-1] > value) begin
          sorted_vals[pos] = sorted_vals[pos-1];
          pos--;
        end
        sorted_vals[pos] = value;
        held++;
      end else begin
        overflowed = 1'b1;
      end
      if (is_last) begin
        if (held % 2 == 1) begin
          res.median_doubled = {sorted_vals[held/2], 1'b0};
        end else begin
          res.median_doubled = {1'b0, sorted_vals[held/2-1]} + {1'b0, sorted_vals[held/2]};
        end
        res.samples_used = USED_W'(held);
        res.truncated = overflowed;
        expected_medians.push_back(res);
        held = 0;
        overflowed = 1'b0;
      end
    endfunction

    // Compare one result transfer with the oldest expected median.
    function void check_result(bit [MED_W-1:0] med, bit [USED_W-1:0] used, bit trunc);
      median_result_t exp_res;
      if (expected_medians.size() == 0) begin
        $error("result transfer with no expected median pending");
        errors++;
        return;
      end
      exp_res = expected_medians.pop_front();
      if (med !== exp_res.median_doubled) begin
        $error("median_doubled: expected %0d, actual %0d", exp_res.median_doubled, med);
        errors++;
      end
      if (used !== exp_res.samples_used) begin
        $error("samples_used: expected %0d, actual %0d", exp_res.samples_used, used);
        errors++;
      end
      if (trunc !== exp_res.truncated) begin
        $error("truncated: expected %0d, actual %0d", exp_res.truncated, trunc);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                sample_valid = 1'b0;
  logic                sample_ready;
  logic [SAMPLE_W-1:0] sample = '0;
  logic                last = 1'b0;
  logic                result_valid;
  logic                result_ready = 1'b0;
  logic [MED_W-1:0]    median_doubled;
  logic [USED_W-1:0]   samples_used;
  logic                truncated;

  median_scoreboard tracker;
  int               samples_sent = 0;

  bounded_sample_median_core u_dut (
    .clk            (clk),
    .rst            (rst),
    .sample_valid   (sample_valid),
    .sample_ready   (sample_ready),
    .sample         (sample),
    .last           (last),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .median_doubled (median_doubled),
    .samples_used   (samples_used),
    .truncated      (truncated)
  );

  always #4 clk = ~clk;

  // Watch both channels and hand every transfer to the scoreboard.
  always @(posedge clk) begin
    if (!rst) begin
      if (sample_valid && sample_ready) begin
        tracker.note_sample(sample, last);
      end
      if (result_valid && result_ready) begin
        tracker.check_result(median_doubled, samples_used, truncated);
      end
    end
  end

  // Offer one sample, after a random gap unless calm is set, and hold it until the transfer.
  task automatic push_sample(input bit [SAMPLE_W-1:0] value, input bit is_last,
                             input bit calm);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= value;
    last <= is_last;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
    samples_sent++;
  endtask

  // Send a whole sequence of the given length and value shape.
  task automatic push_run(input int len, input sample_pattern_t pat, input bit calm);
    bit [SAMPLE_W-1:0] base;
    bit [SAMPLE_W-1:0] value;
    int                i;
    base = SAMPLE_W'($urandom_range(0, 65535));
    for (i = 0; i < len; i++) begin
      case (pat)
        PAT_RANDOM: begin
          value = SAMPLE_W'($urandom_range(0, 65535));
        end
        PAT_CLUSTER: begin
          value = base + SAMPLE_W'($urandom_range(0, 3));
        end
        PAT_EXTREME: begin
          value = $urandom_range(0, 1) ? '1 : '0;
        end
        PAT_DESCENDING: begin
          // Each new sample is smaller, so every insertion shifts the whole store.
          value = SAMPLE_W'((len - i) * 600 + $urandom_range(0, 255));
        end
        default: begin
          value = SAMPLE_W'(i * 600 + $urandom_range(0, 255));
        end
      endcase
      push_sample(value, i == len - 1, calm);
    end
  endtask

  // Take results with random stalls, switching into stall-free stretches now and then.
  task automatic drive_results();
    int gap;
    bit calm;
    calm = 1'b0;
    forever begin
      gap = calm ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        result_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      if ($urandom_range(0, 7) == 0) begin
        calm = !calm;
      end
    end
  endtask

  initial begin
    int              len;
    int              kind;
    int              drain;
    sample_pattern_t pat;
    bit              calm;

    tracker = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    fork
      drive_results();
    join_none

    // Single-sample sequences at both ends of the range.
    push_sample(16'h0000, 1'b1, 1'b0);
    push_sample(16'hFFFF, 1'b1, 1'b0);
    // Two maximum samples give the largest doubled median.
    push_sample(16'hFFFF, 1'b0, 1'b1);
    push_sample(16'hFFFF, 1'b1, 1'b1);
    // Even count with an odd sum, so the half bit is set.
    push_sample(16'h0000, 1'b0, 1'b0);
    push_sample(16'hFFFF, 1'b1, 1'b0);
    // Odd count out of order.
    push_sample(16'd5, 1'b0, 1'b0);
    push_sample(16'd3, 1'b0, 1'b0);
    push_sample(16'd9, 1'b1, 1'b0);
    // Duplicates around the middle of an even count.
    push_sample(16'd7, 1'b0, 1'b1);
    push_sample(16'd7, 1'b0, 1'b1);
    push_sample(16'd1, 1'b0, 1'b1);
    push_sample(16'hFFFF, 1'b1, 1'b1);
    // Mixed order with repeated low values.
    push_sample(16'd100, 1'b0, 1'b0);
    push_sample(16'd200, 1'b0, 1'b0);
    push_sample(16'd50, 1'b0, 1'b0);
    push_sample(16'd50, 1'b0, 1'b0);
    push_sample(16'd300, 1'b0, 1'b0);
    push_sample(16'd10, 1'b1, 1'b0);

    // A store filled exactly, then a last sample that is dropped, then heavy overflow.
    push_run(MAX_SAMPLES, PAT_DESCENDING, 1'b0);
    push_run(MAX_SAMPLES + 1, PAT_RANDOM, 1'b1);
    push_run(100, PAT_CLUSTER, 1'b0);

    // Random sequences, mostly short with an occasional long one that may fill or overflow the store.
    while (samples_sent < 1400) begin
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        len = $urandom_range(60, 90);
      end else if (kind == 1) begin
        len = $urandom_range(MAX_SAMPLES, MAX_SAMPLES + 1);
      end else begin
        len = $urandom_range(1, 16);
      end
      pat = sample_pattern_t'($urandom_range(0, 4));
      calm = ($urandom_range(0, 3) == 0);
      push_run(len, pat, calm);
    end
    sample_valid <= 1'b0;

    // Let the monitor record the final transfer before counting what is still pending.
    @(posedge clk);

    // Drain outstanding results, then allow the insertion latency to settle.
    drain = 0;
    while (tracker.expected_medians.size() != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    repeat (80) @(posedge clk);
    if (tracker.expected_medians.size() != 0) begin
      $error("%0d expected medians never arrived", tracker.expected_medians.size());
      tracker.errors++;
    end
    if (tracker.errors == 0) begin
      $display("bounded_sample_median_core test passed");
    end else begin
      $display("bounded_sample_median_core test failed");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #5_000_000;
    $display("bounded_sample_median_core test failed");
    $finish;
  end

endmodule

// ===== bounded_sample_median_core.f =====
rtl/core/bsm_pkg.sv
rtl/core/bsm_ram.sv
rtl/core/bounded_sample_median_core.sv
verif/tb_bounded_sample_median_core.sv
